### hdl/opsieve_pkg.sv
// Shared constants, field widths and controller/datapath command and status
// structs for the odd-only prime sieve. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package opsieve_pkg;

   localparam int MAX_LIMIT  = 65536;
   localparam int LIMIT_W    = 17;
   localparam int MARK_DEPTH = (MAX_LIMIT + 1) / 2;   // entry i marks odd 2i+1
   localparam int IDX_W      = $clog2(MARK_DEPTH);
   localparam int PROBE_W    = LIMIT_W + 1;           // candidate may run past the limit

   localparam int REQ_DATA_W = ((LIMIT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((LIMIT_W + 2 + 7) / 8) * 8;
   localparam int CSR_DATA_W = ((LIMIT_W + 7) / 8) * 8;

   localparam logic [LIMIT_W-1:0] UPPER_RESET = LIMIT_W'(65536);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(MAX_LIMIT);
   localparam logic [PROBE_W-1:0] FIRST_ODD_PRIME = PROBE_W'(3);
   localparam logic [LIMIT_W-1:0] EVEN_PRIME  = LIMIT_W'(2);

   localparam logic KIND_BUILD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic build_start;    // latch saturated limit, set clear pointer to top
      logic clr_write;      // write zero at clear pointer, step down
      logic sieve_start;    // probe <= first odd prime
      logic probe_step;     // probe += 2
      logic mark_start;     // multiple <= probe squared
      logic mark_write;     // mark multiple, multiple += 2*probe
      logic build_commit;   // built limit valid, zero result
      logic oor_result;     // out-of-range result
      logic query_start;    // latch query, probe <= query
      logic query_self;     // primality of query, probe <= first candidate
      logic next_found;     // next prime <= probe
      logic next_none;      // next prime <= 0
      logic rsp_load;       // move result into output register
   } opsieve_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic sq_over;
      logic probe_marked;
      logic m_over;
      logic req_oor;
      logic below_two;
      logic probe_over;
      logic out_free;
   } opsieve_sts_type;

endpackage

`default_nettype wire

### hdl/opsieve_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module opsieve_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/opsieve_ctrl.sv
// Sequencer for build (clear, sieve, mark) and query (self test, forward scan).
// Depends on opsieve_pkg.
`timescale 1ns / 1ps
`default_nettype none

module opsieve_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   input  wire logic                         req_kind,
   output logic                              req_tready,
   input  wire opsieve_pkg::opsieve_sts_type sts,
   output opsieve_pkg::opsieve_cmd_type      cmd
);
   import opsieve_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SIEVE,
      ST_MARK,
      ST_QSELF,
      ST_QSCAN,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_kind == KIND_BUILD) begin
                  cmd.build_start = 1'b1;
                  state_in        = ST_CLEAR;
               end else if (sts.req_oor) begin
                  cmd.oor_result = 1'b1;
                  state_in       = ST_FIN;
               end else begin
                  cmd.query_start = 1'b1;
                  state_in        = ST_QSELF;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) begin
               cmd.sieve_start = 1'b1;
               state_in        = ST_SIEVE;
            end
         end
         ST_SIEVE: begin
            if (sts.sq_over) begin
               cmd.build_commit = 1'b1;
               state_in         = ST_FIN;
            end else if (sts.probe_marked) begin
               cmd.probe_step = 1'b1;
            end else begin
               cmd.mark_start = 1'b1;
               state_in       = ST_MARK;
            end
         end
         ST_MARK: begin
            if (sts.m_over) begin
               cmd.probe_step = 1'b1;
               state_in       = ST_SIEVE;
            end else begin
               cmd.mark_write = 1'b1;
            end
         end
         ST_QSELF: begin
            cmd.query_self = 1'b1;
            state_in       = sts.below_two ? ST_FIN : ST_QSCAN;
         end
         ST_QSCAN: begin
            if (sts.probe_over) begin
               cmd.next_none = 1'b1;
               state_in      = ST_FIN;
            end else if (!sts.probe_marked) begin
               cmd.next_found = 1'b1;
               state_in       = ST_FIN;
            end else begin
               cmd.probe_step = 1'b1;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

### hdl/opsieve_dp.sv
// Datapath: limit registers, probe and multiple counters, mark store,
// result and output registers. Depends on opsieve_pkg and opsieve_ram.
`timescale 1ns / 1ps
`default_nettype none

module opsieve_dp (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic [opsieve_pkg::LIMIT_W-1:0]         req_query,
   input  wire logic                                    csr_tvalid,
   output logic                                         csr_tready,
   input  wire logic [opsieve_pkg::CSR_DATA_W-1:0]      csr_tdata,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   output logic      [opsieve_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire opsieve_pkg::opsieve_cmd_type            cmd,
   output opsieve_pkg::opsieve_sts_type                 sts
);
   import opsieve_pkg::*;

   logic [LIMIT_W-1:0]    upper_ff;
   logic [LIMIT_W-1:0]    lim_ff;
   logic [LIMIT_W-1:0]    built_limit_ff;
   logic                  built_valid_ff;
   logic [LIMIT_W-1:0]    q_ff;
   logic [PROBE_W-1:0]    probe_ff, probe_in;
   logic [PROBE_W-1:0]    m_ff;
   logic [IDX_W-1:0]      clr_ff;
   logic                  res_prime_ff;
   logic [LIMIT_W-1:0]    res_next_ff;
   logic                  res_oor_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [LIMIT_W-1:0]    lim_sat;
   logic [LIMIT_W-1:0]    lim_m1;
   logic [2*PROBE_W-1:0]  sq;
   logic [PROBE_W-1:0]    cand;
   logic                  q_prime;
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic                  ram_rdata;

   assign lim_sat = (upper_ff > LIMIT_MAX) ? LIMIT_MAX : upper_ff;
   assign lim_m1  = lim_sat - LIMIT_W'(1);
   assign sq      = probe_ff * probe_ff;

   // odd query: step to next odd; even query: the odd just above
   assign cand    = q_ff[0] ? ({1'b0, q_ff} + PROBE_W'(2)) : ({1'b0, q_ff} + PROBE_W'(1));
   assign q_prime = (q_ff == EVEN_PRIME)
                  || (q_ff[0] && (q_ff != LIMIT_W'(1)) && !ram_rdata);

   always_comb begin
      probe_in = probe_ff;
      if (cmd.sieve_start) begin
         probe_in = FIRST_ODD_PRIME;
      end else if (cmd.query_start) begin
         probe_in = {1'b0, req_query};
      end else if (cmd.query_self) begin
         probe_in = cand;
      end else if (cmd.probe_step) begin
         probe_in = probe_ff + PROBE_W'(2);
      end
   end

   assign ram_we    = cmd.clr_write | cmd.mark_write;
   assign ram_waddr = cmd.clr_write ? clr_ff : m_ff[IDX_W:1];

   // read follows the probe's next value, so the mark of probe_ff is on rdata
   opsieve_ram #(
      .WIDTH (1),
      .DEPTH (MARK_DEPTH)
   ) u_marks (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd.mark_write),
      .rd_addr (probe_in[IDX_W:1]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff       <= UPPER_RESET;
         built_limit_ff <= '0;
         built_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_tvalid) begin
            upper_ff <= csr_tdata[LIMIT_W-1:0];
         end
         if (cmd.build_commit) begin
            built_limit_ff <= lim_ff;
            built_valid_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      if (cmd.build_start) begin
         lim_ff <= lim_sat;
         // top index of the largest odd within the limit; clear runs downward
         clr_ff <= (lim_sat == '0) ? '0 : lim_m1[IDX_W:1];
      end
      if (cmd.clr_write) begin
         clr_ff <= clr_ff - IDX_W'(1);
      end
      if (cmd.mark_start) begin
         m_ff <= sq[PROBE_W-1:0];
      end else if (cmd.mark_write) begin
         m_ff <= m_ff + {probe_ff[PROBE_W-2:0], 1'b0};
      end
      if (cmd.query_start) begin
         q_ff       <= req_query;
         res_oor_ff <= 1'b0;
      end
      if (cmd.build_commit) begin
         res_prime_ff <= 1'b0;
         res_next_ff  <= '0;
         res_oor_ff   <= 1'b0;
      end
      if (cmd.oor_result) begin
         res_prime_ff <= 1'b0;
         res_next_ff  <= '0;
         res_oor_ff   <= 1'b1;
      end
      if (cmd.query_self) begin
         res_prime_ff <= q_prime;
         res_next_ff  <= (built_limit_ff >= EVEN_PRIME) ? EVEN_PRIME : '0;
      end
      if (cmd.next_found) begin
         res_next_ff <= probe_ff[LIMIT_W-1:0];
      end
      if (cmd.next_none) begin
         res_next_ff <= '0;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {(RSP_DATA_W - LIMIT_W - 2)'(0), res_oor_ff, res_next_ff, res_prime_ff};
      end
   end

   assign sts.clr_last     = (clr_ff == '0);
   assign sts.sq_over      = sq > {(2*PROBE_W - LIMIT_W)'(0), lim_ff};
   assign sts.probe_marked = ram_rdata;
   assign sts.m_over       = m_ff > {1'b0, lim_ff};
   assign sts.req_oor      = !built_valid_ff || (req_query > built_limit_ff);
   assign sts.below_two    = (q_ff < EVEN_PRIME);
   assign sts.probe_over   = probe_ff > {1'b0, built_limit_ff};
   assign sts.out_free     = !rsp_valid_ff || rsp_tready;

   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/odd_only_prime_sieve.sv
// Top level of the odd-only prime sieve: sequencer plus datapath with mark store.
// Depends on opsieve_pkg, opsieve_ctrl, opsieve_dp, opsieve_ram.
//
//   channel | dir | handshake              | contents
//   req     | in  | req_tvalid/req_tready  | tuser kind, tdata query_value
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata is_prime, next_prime, out_of_range
//   csr     | in  | csr_tvalid/csr_tready  | tdata upper_limit
//
// Build: clear the marks (L = saturated limit), step each odd probe with square
// within L, mark the multiples of each unmarked probe, commit and load the result.
// Query: test the query itself, then for a query of two or more scan odd candidates
// up to the prime found or the first past the limit; out of range, go straight to
// the result. One word in work at a time; the next is taken while a result waits
// in the output register. No clearing pass after reset: builds clear.
`timescale 1ns / 1ps
`default_nettype none

module odd_only_prime_sieve (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic                                req_tuser,  // [0] kind
   input  wire logic [opsieve_pkg::REQ_DATA_W-1:0]  req_tdata,  // [16:0] query_value
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] is_prime, [17:1] next_prime, [18] out_of_range
   output logic      [opsieve_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                                csr_tvalid,
   output logic                                     csr_tready,
   input  wire logic [opsieve_pkg::CSR_DATA_W-1:0]  csr_tdata   // [16:0] upper_limit
);
   import opsieve_pkg::*;

   opsieve_cmd_type cmd;
   opsieve_sts_type sts;

   opsieve_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   opsieve_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_query  (req_tdata[LIMIT_W-1:0]),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

### verif/odd_only_prime_sieve_tb.sv
// Self-checking bench for odd_only_prime_sieve: directed builds and queries, then
// random queries over several sieve limits, with random stalls on both stream sides.
// Depends on opsieve_pkg and the odd_only_prime_sieve RTL.
`timescale 1ns / 1ps

module odd_only_prime_sieve_tb;
   import opsieve_pkg::*;

   localparam int               ODD_SLOTS   = MAX_LIMIT / 2 + 1;
   localparam int unsigned      STALL_LIMIT = 400000;
   localparam bit [LIMIT_W-1:0] FIELD_TOP   = '1;

   typedef struct packed {
      bit               is_prime;
      bit [LIMIT_W-1:0] next_prime;
      bit               out_of_range;
   } sieve_answer_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tuser  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_tvalid = 1'b0;
   logic [CSR_DATA_W-1:0] csr_tdata  = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_tready;

   // mirror of the block: marks, built limit and the limit register
   bit               odd_marks [ODD_SLOTS];
   int unsigned      sieved_limit = 0;
   bit               sieve_ready  = 1'b0;
   bit [LIMIT_W-1:0] limit_reg    = UPPER_RESET;

   sieve_answer_type answers_due[$];
   int unsigned      mismatches   = 0;
   int unsigned      quiet_cycles = 0;
   int unsigned      req_calm     = 0;
   int unsigned      rsp_calm     = 0;
   int unsigned      rsp_stall    = 0;

   odd_only_prime_sieve dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always #10 clock = ~clock;

   function automatic void sieve_build();
      int unsigned lim, p, m;
      lim = limit_reg;
      if (lim > MAX_LIMIT) lim = MAX_LIMIT;
      foreach (odd_marks[i]) odd_marks[i] = 1'b0;
      for (p = 3; p * p <= lim; p += 2) begin
         if (!odd_marks[(p - 1) >> 1]) begin
            for (m = p * p; m <= lim; m += 2 * p) odd_marks[(m - 1) >> 1] = 1'b1;
         end
      end
      sieved_limit = lim;
      sieve_ready  = 1'b1;
   endfunction

   // caller keeps m within the sieved limit
   function automatic bit prime_at(int unsigned m);
      if (m == EVEN_PRIME) return 1'b1;
      if (m < 2 || m[0] == 1'b0) return 1'b0;
      return !odd_marks[(m - 1) >> 1];
   endfunction

   function automatic sieve_answer_type sieve_answer(logic kind, bit [LIMIT_W-1:0] q);
      sieve_answer_type ans;
      int unsigned      c;
      ans = '0;
      if (kind == KIND_BUILD) begin
         sieve_build();
         return ans;
      end
      if (!sieve_ready || q > sieved_limit) begin
         ans.out_of_range = 1'b1;
         return ans;
      end
      ans.is_prime = prime_at(q);
      for (c = q + 1; c <= sieved_limit; c++) begin
         if (prime_at(c)) begin
            ans.next_prime = c[LIMIT_W-1:0];
            break;
         end
      end
      return ans;
   endfunction

   // mostly no gap, some short ones, a few long, plus runs with no gaps at all
   function automatic int unsigned pick_gap(inout int unsigned calm_left);
      int unsigned r;
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic bit [LIMIT_W-1:0] pick_query();
      int unsigned r, lim;
      lim = sieved_limit;
      r = $urandom_range(0, 99);
      if (r < 65) return LIMIT_W'($urandom_range(0, lim));
      if (r < 78) return LIMIT_W'($urandom_range(lim > 40 ? lim - 40 : 0, lim));
      if (r < 88) return LIMIT_W'($urandom_range(0, 20));
      if (lim < FIELD_TOP) return LIMIT_W'($urandom_range(lim + 1, FIELD_TOP));
      return LIMIT_W'(lim);
   endfunction

   task automatic send_word(input logic kind, input bit [LIMIT_W-1:0] value);
      int unsigned gap;
      gap = pick_gap(req_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'(value);
      do @(posedge clock); while (!req_tready);
      answers_due = {answers_due, sieve_answer(kind, value)};
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   task automatic set_upper_limit(input bit [LIMIT_W-1:0] value);
      wait_drained();
      csr_tvalid <= 1'b1;
      csr_tdata  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_tready);
      limit_reg = value;
      csr_tvalid <= 1'b0;
   endtask

   task automatic check_answer();
      sieve_answer_type want;
      if (answers_due.size() == 0) begin
         $display("%0t: result word %h with none expected", $time, rsp_tdata);
         mismatches++;
      end else begin
         want = answers_due.pop_front();
         if (rsp_tdata[0] !== want.is_prime) begin
            $display("%0t: is_prime expected %0d, got %0d", $time, want.is_prime,
                     rsp_tdata[0]);
            mismatches++;
         end
         if (rsp_tdata[LIMIT_W:1] !== want.next_prime) begin
            $display("%0t: next_prime expected %0d, got %0d", $time, want.next_prime,
                     rsp_tdata[LIMIT_W:1]);
            mismatches++;
         end
         if (rsp_tdata[LIMIT_W+1] !== want.out_of_range) begin
            $display("%0t: out_of_range expected %0d, got %0d", $time,
                     want.out_of_range, rsp_tdata[LIMIT_W+1]);
            mismatches++;
         end
      end
   endtask

   // result side: check each accepted word, then pick the next ready level
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_answer();
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_stall = pick_gap(rsp_calm);
            rsp_tready <= (rsp_stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("odd_only_prime_sieve verification failed");
            $finish;
         end
      end
   end

   task automatic test_unbuilt_queries();
      send_word(KIND_QUERY, 5);
      send_word(KIND_QUERY, 0);
      send_word(KIND_QUERY, FIELD_TOP);
   endtask

   // reset limit covers the whole store
   task automatic test_full_sieve();
      send_word(KIND_BUILD, 17'h1abcd);
      send_word(KIND_QUERY, 0);
      send_word(KIND_QUERY, 1);
      send_word(KIND_QUERY, 2);
      send_word(KIND_QUERY, 3);
      send_word(KIND_QUERY, 4);
      send_word(KIND_QUERY, 9);
      send_word(KIND_QUERY, 25);
      send_word(KIND_QUERY, 65521);   // last prime, nothing above it
      send_word(KIND_QUERY, LIMIT_MAX);
      send_word(KIND_QUERY, LIMIT_W'(MAX_LIMIT + 1));
   endtask

   task automatic test_tiny_limits();
      set_upper_limit(2);
      send_word(KIND_BUILD, 0);
      send_word(KIND_QUERY, 1);
      send_word(KIND_QUERY, 2);
      send_word(KIND_QUERY, 3);
      set_upper_limit(0);
      send_word(KIND_BUILD, FIELD_TOP);
      send_word(KIND_QUERY, 0);
      send_word(KIND_QUERY, 1);
   endtask

   // new limit must not matter until the next build; then it saturates
   task automatic test_saturation_and_stale();
      set_upper_limit(FIELD_TOP);
      send_word(KIND_QUERY, 0);
      send_word(KIND_BUILD, 0);
      send_word(KIND_QUERY, LIMIT_MAX);
      send_word(KIND_QUERY, FIELD_TOP);
   endtask

   task automatic test_random_full_range();
      int unsigned k;
      for (k = 0; k < 700; k++) send_word(KIND_QUERY, pick_query());
   endtask

   task automatic test_random_limits();
      int unsigned done_words, phase_len, lim, r, k;
      done_words = 0;
      while (done_words < 1150) begin
         r = $urandom_range(0, 99);
         if (r < 12)      lim = $urandom_range(0, 16);
         else if (r < 75) lim = $urandom_range(17, 3000);
         else if (r < 94) lim = $urandom_range(3001, 20000);
         else if (r < 98) lim = $urandom_range(20001, MAX_LIMIT - 1);
         else             lim = $urandom_range(MAX_LIMIT, FIELD_TOP);
         set_upper_limit(LIMIT_W'(lim));
         // now and then keep querying the old sieve first
         if ($urandom_range(0, 9) != 0) begin
            send_word(KIND_BUILD, LIMIT_W'($urandom_range(0, FIELD_TOP)));
            done_words++;
         end
         phase_len = $urandom_range(20, 100);
         for (k = 0; k < phase_len; k++) begin
            if ($urandom_range(0, 99) < 3 && limit_reg <= 20000)
               send_word(KIND_BUILD, LIMIT_W'($urandom_range(0, FIELD_TOP)));
            else
               send_word(KIND_QUERY, pick_query());
            done_words++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_unbuilt_queries();
      test_full_sieve();
      test_tiny_limits();
      test_saturation_and_stale();
      test_random_full_range();
      test_random_limits();
      wait_drained();
      repeat (64) @(posedge clock);
      if (mismatches == 0)
         $display("odd_only_prime_sieve verification clean");
      else
         $display("odd_only_prime_sieve verification failed");
      $finish;
   end

endmodule
